>>> hdl/edi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edi_pkg
// Shared widths, types and the square root step for the distance unit.
// ----------------------------------------------------------------------------
package edi_pkg;

  // field widths
  localparam int COORD_W = 15;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int RAD_W   = 32;
  localparam int DIST_W  = 16;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = ((4 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

  // root pipeline shape: one result bit per iteration, two iterations a stage
  localparam int SQRT_ITERS      = RAD_W / 2;
  localparam int ITERS_PER_STAGE = 2;
  localparam int SQRT_STAGES     = SQRT_ITERS / ITERS_PER_STAGE;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [SQ_W-1:0]    sq_t;
  typedef logic        [RAD_W-1:0]   rad_t;
  typedef logic        [DIST_W-1:0]  dist_t;

  // partial remainder and root carried between root stages
  typedef struct packed {
    rad_t rem;
    rad_t root;
  } sqrt_state_t;

  // one bit-pair step; iteration k tests the bit at position RAD_W-2-2k
  function automatic sqrt_state_t sqrt_iter(input sqrt_state_t s, input int k);
    rad_t        bit_v;
    rad_t        trial;
    sqrt_state_t r;
    bit_v = rad_t'(1) << (RAD_W - 2 - 2 * k);
    trial = s.root + bit_v;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + bit_v;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

>>> hdl/edi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edi_front
// Three-stage front end: coordinate differences and magnitudes, squares,
// then the sum of squares as the radicand.
// ----------------------------------------------------------------------------
module edi_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  edi_pkg::coord_t first_x,
  input  edi_pkg::coord_t first_y,
  input  edi_pkg::coord_t second_x,
  input  edi_pkg::coord_t second_y,
  output logic           out_valid,
  input  logic           out_ready,
  output edi_pkg::rad_t  out_rad
);
  import edi_pkg::*;

  logic  s1_valid_r, s2_valid_r, s3_valid_r;
  logic  s1_ready, s2_ready, s3_ready;
  diff_t dx, dy;
  mag_t  ax_nxt, ay_nxt, ax_r, ay_r;
  sq_t   sqx_nxt, sqy_nxt, sqx_r, sqy_r;
  rad_t  rad_nxt, rad_r;

  // per-stage ready, a stage moves when empty or its successor takes
  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // differences and their magnitudes
  always_comb begin
    dx     = diff_t'(first_x) - diff_t'(second_x);
    dy     = diff_t'(first_y) - diff_t'(second_y);
    ax_nxt = dx[DIFF_W-1] ? mag_t'(-dx) : mag_t'(dx);
    ay_nxt = dy[DIFF_W-1] ? mag_t'(-dy) : mag_t'(dy);
  end

  // squares
  assign sqx_nxt = sq_t'(ax_r) * sq_t'(ax_r);
  assign sqy_nxt = sq_t'(ay_r) * sq_t'(ay_r);

  // sum of squares, always within the radicand width
  assign rad_nxt = rad_t'(sqx_r) + rad_t'(sqy_r);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end
    if (s2_ready) begin
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
    end
    if (s3_ready) begin
      rad_r <= rad_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_rad   = rad_r;

endmodule

>>> hdl/edi_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edi_sqrt_pipe
// Pipelined bit-pair integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module edi_sqrt_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  edi_pkg::rad_t  in_rad,
  output logic           out_valid,
  input  logic           out_ready,
  output edi_pkg::dist_t out_root
);
  import edi_pkg::*;

  logic        valid_r [SQRT_STAGES];
  logic        ready   [SQRT_STAGES];
  sqrt_state_t st_r    [SQRT_STAGES];
  sqrt_state_t st_nxt  [SQRT_STAGES];
  sqrt_state_t st_in;

  // remainder starts as the radicand, root as zero
  always_comb begin
    st_in.rem  = in_rad;
    st_in.root = '0;
  end

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    sqrt_state_t prev;
    sqrt_state_t mid;
    logic        prev_valid;

    // stage input from the previous stage or the entry
    if (g == 0) begin : g_first
      assign prev       = st_in;
      assign prev_valid = in_valid;
    end else begin : g_next
      assign prev       = st_r[g-1];
      assign prev_valid = valid_r[g-1];
    end

    // stage ready, chained back from the output
    if (g == SQRT_STAGES - 1) begin : g_last
      assign ready[g] = !valid_r[g] || out_ready;
    end else begin : g_mid
      assign ready[g] = !valid_r[g] || ready[g+1];
    end

    // two bit-pair iterations
    always_comb begin
      mid       = sqrt_iter(prev, ITERS_PER_STAGE * g);
      st_nxt[g] = sqrt_iter(mid, ITERS_PER_STAGE * g + 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (ready[g]) begin
        valid_r[g] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (ready[g]) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign in_ready  = ready[0];
  assign out_valid = valid_r[SQRT_STAGES-1];
  assign out_root  = st_r[SQRT_STAGES-1].root[DIST_W-1:0];

endmodule

>>> hdl/euclidean_distance_isqrt_unit.sv
`timescale 1ns / 1ps
// pipeline: 3 front stages, then 8 root stages of two bit-pair iterations each
// throughput: one request per cycle unless the output is held and all stages
// are full; every stage is a register with its own valid bit, so an idle
// stage fills even while the output is held
// reset: synchronous active-low rst_n clears all valid bits, payload is kept
// ----------------------------------------------------------------------------
// euclidean_distance_isqrt_unit
// Floor of the Euclidean distance between two signed 15-bit 2-D points.
// ----------------------------------------------------------------------------
module euclidean_distance_isqrt_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // first_x [14:0], first_y [29:15], second_x [44:30], second_y [59:45], [63:60] unused
  input  logic [edi_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // distance [15:0]
  output logic [edi_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import edi_pkg::*;

  coord_t first_x, first_y, second_x, second_y;
  logic   rad_valid, rad_ready;
  rad_t   rad;
  dist_t  root_dist;

  // unpack the request
  assign first_x  = coord_t'(in_tdata[0*COORD_W +: COORD_W]);
  assign first_y  = coord_t'(in_tdata[1*COORD_W +: COORD_W]);
  assign second_x = coord_t'(in_tdata[2*COORD_W +: COORD_W]);
  assign second_y = coord_t'(in_tdata[3*COORD_W +: COORD_W]);

  // sum of squares
  edi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .out_valid (rad_valid),
    .out_ready (rad_ready),
    .out_rad   (rad)
  );

  // integer square root
  edi_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rad_valid),
    .in_ready  (rad_ready),
    .in_rad    (rad),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_root  (root_dist)
  );

  assign out_tdata = OUT_DATA_W'(root_dist);

endmodule

>>> bench/tb_euclidean_distance_isqrt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euclidean_distance_isqrt_unit
// Streams point pairs into the distance unit and checks every result in order
// against a known distance or a bit-pair square root predictor, under several
// idling patterns and a long output hold-off that stalls the whole pipeline.
// ----------------------------------------------------------------------------
module tb_euclidean_distance_isqrt_unit;

  import edi_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 5;
  localparam int PIPE_LATENCY = 11;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // how the coordinates of a random request are spread
  typedef enum int {
    SPREAD_FULL,
    SPREAD_SMALL,
    SPREAD_EDGE,
    SPREAD_NEAR
  } spread_t;

  // directed row: two points, and the distance where it is known by hand
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    logic   known;
    dist_t  known_dist;
  } point_row_t;

  localparam int ROW_COUNT = 22;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  logic hold_active = 1'b0;
  int fault_count = 0;
  int cycle_count = 0;
  dist_t pending_dist_q[$];

  point_row_t point_rows [ROW_COUNT] = '{
    '{15'sd0, 15'sd0, 15'sd0, 15'sd0, 1'b1, 16'd0},
    // coincident points away from the origin
    '{15'sd5, -15'sd7, 15'sd5, -15'sd7, 1'b1, 16'd0},
    // opposite corners, largest radicand
    '{-15'sd16384, -15'sd16384, 15'sd16383, 15'sd16383, 1'b1, 16'd46339},
    '{15'sd16383, 15'sd16383, -15'sd16384, -15'sd16384, 1'b1, 16'd46339},
    '{-15'sd16384, 15'sd16383, 15'sd16383, -15'sd16384, 1'b1, 16'd46339},
    '{15'sd16383, -15'sd16384, -15'sd16384, 15'sd16383, 1'b1, 16'd46339},
    // one axis at full span
    '{-15'sd16384, 15'sd0, 15'sd16383, 15'sd0, 1'b1, 16'd32767},
    '{15'sd0, 15'sd16383, 15'sd0, -15'sd16384, 1'b1, 16'd32767},
    '{15'sd3, 15'sd4, 15'sd0, 15'sd0, 1'b1, 16'd5},
    '{15'sd0, 15'sd0, -15'sd3, -15'sd4, 1'b1, 16'd5},
    '{15'sd1, 15'sd0, 15'sd0, 15'sd0, 1'b1, 16'd1},
    '{-15'sd1, -15'sd1, 15'sd0, 15'sd0, 1'b1, 16'd1},
    '{15'sd16383, 15'sd16383, 15'sd16383, 15'sd16383, 1'b1, 16'd0},
    '{-15'sd16384, -15'sd16384, -15'sd16384, -15'sd16384, 1'b1, 16'd0},
    '{15'sd0, 15'sd0, 15'sd16383, 15'sd0, 1'b1, 16'd16383},
    '{15'sd0, 15'sd0, -15'sd16384, -15'sd16384, 1'b0, 16'd0},
    '{-15'sd16384, 15'sd16383, 15'sd0, 15'sd0, 1'b0, 16'd0},
    '{15'sd12345, -15'sd2345, -15'sd9876, 15'sd7777, 1'b0, 16'd0},
    '{15'sd2, 15'sd2, 15'sd0, 15'sd0, 1'b1, 16'd2},
    '{15'sd0, 15'sd0, 15'sd1, 15'sd3, 1'b1, 16'd3},
    // exact square, 61 squared
    '{15'sd11, 15'sd0, 15'sd0, 15'sd60, 1'b1, 16'd61},
    '{15'sd0, 15'sd0, -15'sd10922, 15'sd5461, 1'b0, 16'd0}
  };

  euclidean_distance_isqrt_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // floor of the distance, digit-by-digit root over a 32-bit radicand
  function automatic dist_t predict_distance(input coord_t ax, input coord_t ay,
                                             input coord_t bx, input coord_t by);
    int dx;
    int dy;
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] probe;
    dx = int'(ax) - int'(bx);
    dy = int'(ay) - int'(by);
    // at most 2 * 32767^2, which stays below 2^31
    rem = dx * dx + dy * dy;
    root = '0;
    probe = 32'h4000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return dist_t'(root);
  endfunction

  function automatic coord_t pick_coord(input spread_t spread);
    case (spread)
      SPREAD_SMALL: return coord_t'($urandom_range(0, 40) - 20);
      SPREAD_EDGE: begin
        if ($urandom_range(0, 1) == 1) return coord_t'(16383 - $urandom_range(0, 3));
        return coord_t'(-16384 + $urandom_range(0, 3));
      end
      default: return coord_t'($urandom_range(0, 32767));
    endcase
  endfunction

  // offer one request, record what it must produce once it is taken
  task automatic offer_points(input coord_t ax, input coord_t ay, input coord_t bx,
                              input coord_t by, input logic known,
                              input dist_t known_dist);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({by, bx, ay, ax});
    do @(posedge clk); while (!in_tready);
    pending_dist_q.push_back(known ? known_dist : predict_distance(ax, ay, bx, by));
  endtask

  task automatic offer_random(input int count);
    spread_t spread;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      spread = (pick < 4) ? SPREAD_FULL : (pick < 6) ? SPREAD_SMALL :
               (pick < 8) ? SPREAD_EDGE : SPREAD_NEAR;
      ax = pick_coord(spread == SPREAD_NEAR ? SPREAD_FULL : spread);
      ay = pick_coord(spread == SPREAD_NEAR ? SPREAD_FULL : spread);
      if (spread == SPREAD_NEAR) begin
        // close points anywhere in the range: short distances, coordinates of any size
        bx = ax + coord_t'($urandom_range(0, 6) - 3);
        by = ay + coord_t'($urandom_range(0, 6) - 3);
      end else begin
        bx = pick_coord(spread);
        by = pick_coord(spread);
      end
      offer_points(ax, ay, bx, by, 1'b0, '0);
    end
  endtask

  // drain, then switch the idling pattern away from the clock edge
  task automatic change_idling(input int send_pct, input int recv_pct);
    in_tvalid <= 1'b0;
    while (pending_dist_q.size() != 0) @(posedge clk);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    @(posedge clk);
  endtask

  // result side ready, random stalls, forced low during the hold-off
  always @(posedge clk) begin
    out_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long output hold-off so the pipeline fills and stalls its input
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // compare each result with the oldest pending distance
  always @(posedge clk) begin
    dist_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dist_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected result: distance %0d with nothing pending",
                   out_tdata[DIST_W-1:0]);
      end else begin
        want = pending_dist_q.pop_front();
        if (out_tdata[DIST_W-1:0] !== want) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("distance mismatch: expected %0d, got %0d", want,
                     out_tdata[DIST_W-1:0]);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("euclidean_distance_isqrt_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests, no idling
    foreach (point_rows[i])
      offer_points(point_rows[i].ax, point_rows[i].ay, point_rows[i].bx,
                   point_rows[i].by, point_rows[i].known, point_rows[i].known_dist);
    offer_random(300);

    change_idling(79, 0);
    offer_random(300);

    change_idling(0, 79);
    offer_random(300);

    change_idling(25, 25);
    offer_random(400);

    // back-pressure: sender keeps offering while the output is held off
    change_idling(0, 0);
    hold_request = 1'b1;
    offer_random(300);

    in_tvalid <= 1'b0;
    while (pending_dist_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (fault_count == 0) begin
      $display("euclidean_distance_isqrt_unit verification clean");
    end else begin
      $display("euclidean_distance_isqrt_unit verification failed");
    end
    $finish;
  end

endmodule

>>> euclidean_distance_isqrt_unit.f
hdl/edi_pkg.sv
hdl/edi_front.sv
hdl/edi_sqrt_pipe.sv
hdl/euclidean_distance_isqrt_unit.sv
bench/tb_euclidean_distance_isqrt_unit.sv
